FILE: rtl/core/sma_pkg.sv
// Shared constants for the simple moving average block.
// No dependencies; the top level refers to these by scoped name.
package sma_pkg;

  // Default ring depth and the fixed field widths.
  localparam int unsigned MAX_WINDOW_DEF = 256;
  localparam int unsigned SAMPLE_W       = 32;
  localparam int unsigned WIN_CFG_W      = 9;
  localparam int unsigned CFG_DATA_W     = 32;
  localparam int unsigned CFG_ADDR_W     = 3;

  // Register map: index 0 holds window_length.
  localparam logic       REG_WINDOW_LENGTH = 1'b0;
  localparam logic [8:0] WINDOW_RESET      = 9'd5;

endpackage

FILE: rtl/core/simple_moving_average_top.sv
// Streaming simple moving average (boxcar) over unsigned Q16.16 samples.
// Depends on sma_pkg for widths, register map and reset values.
//
// Each input transaction carries one 32-bit sample in in_tdata and a series
// start flag in in_tuser; each one yields exactly one output transaction with
// the mean of the last window_length samples (truncated toward zero) in
// out_tdata and a window-full flag in out_tuser. Until window_length samples
// of the current series have arrived, the mean reads 0 and the flag is low.
// window_length lives at byte address 0 of the APB-style port; a value of 0
// acts as 1 and a value above MAX_WINDOW acts as MAX_WINDOW, and every write
// restarts the series. Write it only while the block is idle. Sequencing: the
// block works on one sample at a time and deasserts in_tready until it is
// done. A sample that slides a full window passes through S_RD (read of the
// outgoing slot), S_SUB, S_ADD, S_DIV and S_OUT before the block can accept
// again. S_DIV runs the restoring divider, which retires one quotient bit
// per cycle of the running sum, SUM_W = 32 + log2(MAX_WINDOW) bits wide, on
// the single shared add/subtract unit that also updates the running sum. The
// sample that first fills the window skips the subtract of the outgoing
// sample (S_SUB); a sample that leaves the window unfilled skips both the
// subtract and the divider. While the previous result still waits in the
// output register, the block stays in S_OUT until out_tready takes it.
// The ring of samples is a single-port-write, registered-read memory; no
// clearing pass is needed since only entries of the current series are read.
module simple_moving_average_top #(
  parameter int unsigned MAX_WINDOW = sma_pkg::MAX_WINDOW_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [sma_pkg::SAMPLE_W-1:0]    in_tdata,   // [31:0] sample_price
  input  logic                            in_tuser,   // [0] series_start
  // Result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [sma_pkg::SAMPLE_W-1:0]    out_tdata,  // [31:0] average
  output logic                            out_tuser,  // [0] window_full
  // Configuration port
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [sma_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [sma_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [sma_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);

  localparam int unsigned DW    = sma_pkg::SAMPLE_W;
  localparam int unsigned CW    = sma_pkg::WIN_CFG_W;
  localparam int unsigned AW    = $clog2(MAX_WINDOW);       // ring address
  localparam int unsigned WW    = $clog2(MAX_WINDOW + 1);   // window / count
  localparam int unsigned SUM_W = DW + AW;                  // running sum
  localparam int unsigned OW    = AW + 2;                   // oldest-slot math
  localparam int unsigned CNT_W = $clog2(SUM_W);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_SUB  = 3'd2;
  localparam logic [2:0] S_ADD  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [CW-1:0]    window_r;
  logic [SUM_W-1:0] sum_r;
  logic [WW-1:0]    seen_r;
  logic [AW-1:0]    pos_r;
  logic [DW-1:0]    sample_r;
  logic [DW-1:0]    old_r;
  logic [SUM_W-1:0] quo_r;
  logic [WW-1:0]    rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             full_r;
  logic             out_valid_r;
  logic [DW-1:0]    out_avg_r;
  logic             out_full_r;

  logic [DW-1:0]    sample_ring [MAX_WINDOW];

  // ------------------------------------------------------------------
  // Configuration port: single register, word aligned, ignore beyond it.
  // ------------------------------------------------------------------
  logic cfg_wr;
  logic cfg_hit;

  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[2] == sma_pkg::REG_WINDOW_LENGTH);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit;
  assign cfg_prdata = cfg_hit ? sma_pkg::CFG_DATA_W'(window_r) : '0;

  // Effective window: clamp to 1..MAX_WINDOW.
  logic [WW-1:0] win_eff;
  always_comb begin
    if (window_r == '0) begin
      win_eff = WW'(1);
    end else if (32'(window_r) > 32'(MAX_WINDOW)) begin
      win_eff = WW'(MAX_WINDOW);
    end else begin
      win_eff = WW'(window_r);
    end
  end

  // Slot of the sample that drops out of the window.
  logic [OW-1:0] old_tmp;
  logic [AW-1:0] old_addr;
  always_comb begin
    old_tmp = OW'(pos_r) + OW'(MAX_WINDOW) - OW'(win_eff);
    if (old_tmp >= OW'(MAX_WINDOW)) begin
      old_tmp = old_tmp - OW'(MAX_WINDOW);
    end
    old_addr = AW'(old_tmp);
  end

  logic          window_now_full;
  logic [WW-1:0] seen_inc;
  logic [AW-1:0] pos_inc;
  assign window_now_full = (seen_r >= win_eff);
  assign seen_inc = window_now_full ? seen_r : seen_r + WW'(1);
  assign pos_inc  = (pos_r == AW'(MAX_WINDOW - 1)) ? '0 : pos_r + AW'(1);

  // ------------------------------------------------------------------
  // Shared add/subtract unit: sum update and each division step.
  // ------------------------------------------------------------------
  logic [SUM_W-1:0] alu_a, alu_b;
  logic             alu_sub;
  logic [SUM_W:0]   alu_res;
  logic [WW:0]      div_shift;

  assign div_shift = {rem_r, quo_r[SUM_W-1]};

  always_comb begin
    alu_a   = sum_r;
    alu_b   = SUM_W'(sample_r);
    alu_sub = 1'b0;
    case (state_r)
      S_SUB: begin
        alu_b   = SUM_W'(old_r);
        alu_sub = 1'b1;
      end
      S_DIV: begin
        alu_a   = SUM_W'(div_shift);
        alu_b   = SUM_W'(win_eff);
        alu_sub = 1'b1;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
    alu_res = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b}) : ({1'b0, alu_a} + {1'b0, alu_b});
  end

  // Borrow out of the divide step means the remainder stays as shifted.
  logic div_bit;
  assign div_bit = ~alu_res[SUM_W];

  // ------------------------------------------------------------------
  // Sequencer
  // ------------------------------------------------------------------
  logic in_fire, out_load;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_RD;
      S_RD:   state_nxt = window_now_full ? S_SUB : S_ADD;
      S_SUB:  state_nxt = S_ADD;
      S_ADD:  state_nxt = (seen_inc >= win_eff) ? S_DIV : S_OUT;
      S_DIV:  if (cnt_r == CNT_W'(SUM_W - 1)) state_nxt = S_OUT;
      S_OUT:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      window_r    <= sma_pkg::WINDOW_RESET;
      sum_r       <= '0;
      seen_r      <= '0;
      pos_r       <= '0;
      full_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_wr) begin
        // Restart the series so the sum always matches the window.
        window_r <= cfg_pwdata[CW-1:0];
        sum_r    <= '0;
        seen_r   <= '0;
        pos_r    <= '0;
      end else begin
        unique case (state_r)
          S_IDLE: begin
            if (in_fire && in_tuser) begin
              sum_r  <= '0;
              seen_r <= '0;
              pos_r  <= '0;
            end
          end
          S_SUB: sum_r <= alu_res[SUM_W-1:0];
          S_ADD: begin
            sum_r  <= alu_res[SUM_W-1:0];
            seen_r <= seen_inc;
            pos_r  <= pos_inc;
            full_r <= (seen_inc >= win_eff);
            cnt_r  <= '0;
          end
          S_DIV: cnt_r <= cnt_r + CNT_W'(1);
          default: begin
            cnt_r <= cnt_r;
          end
        endcase
      end

      // Hold a result until taken; a new one may replace it on the same edge.
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      sample_r <= in_tdata;
    end
    if (state_r == S_ADD) begin
      quo_r <= alu_res[SUM_W-1:0];
      rem_r <= '0;
    end else if (state_r == S_DIV) begin
      quo_r <= {quo_r[SUM_W-2:0], div_bit};
      rem_r <= div_bit ? alu_res[WW-1:0] : div_shift[WW-1:0];
    end
    if (out_load) begin
      out_avg_r  <= full_r ? quo_r[DW-1:0] : '0;
      out_full_r <= full_r;
    end
  end

  // Sample ring: read the outgoing slot, then write the new sample.
  always_ff @(posedge clk) begin
    if (state_r == S_RD) begin
      old_r <= sample_ring[old_addr];
    end
    if (state_r == S_ADD) begin
      sample_ring[pos_r] <= sample_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_avg_r;
  assign out_tuser  = out_full_r;

`ifndef ASSERT_OFF
  // Count never runs past the effective window.
  a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (seen_r <= win_eff))
    else $error("sample count exceeds window");

  // Partial remainder stays below the divisor throughout the division.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < win_eff))
    else $error("divider remainder out of range");

  // Division ends after exactly one step per sum bit.
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && cnt_r == CNT_W'(SUM_W - 1)) |=> (state_r == S_OUT))
    else $error("divider did not finish on time");

  // An unfilled window always reports a zero mean.
  a_zero_unfull: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_full_r) |-> (out_avg_r == '0))
    else $error("nonzero average before window full");
`endif

endmodule

FILE: tb/simple_moving_average_top_tb.sv
// Self-checking testbench for simple_moving_average_top: directed table, then random phases.
// Predicts each boxcar average in-bench and checks out_tdata/out_tuser in order.
// Depends on sma_pkg and the RTL of simple_moving_average_top only.
`timescale 1ns / 100ps

module simple_moving_average_top_tb;

  localparam logic [8:0] MAX_W = 9'(sma_pkg::MAX_WINDOW_DEF);
  localparam logic [sma_pkg::CFG_ADDR_W-1:0] WINDOW_ADDR =
    sma_pkg::CFG_ADDR_W'(sma_pkg::REG_WINDOW_LENGTH) << 2;

  // One result transaction: average in tdata, window-full flag in tuser.
  typedef struct packed {
    logic [31:0] average;
    logic        window_full;
  } sma_result_t;

  // Directed table row: either a sample transaction or a window_length write.
  typedef enum logic {ROW_SAMPLE, ROW_WINDOW} row_kind_t;
  typedef struct packed {
    row_kind_t   kind;
    logic [31:0] value;
    logic        start;
    logic        known;      // expected result typed in below
    logic [31:0] exp_avg;
    logic        exp_full;
  } dir_row_t;

  localparam int NUM_ROWS = 25;
  localparam logic [31:0] PMAX = 32'hFFFF_FFFF;

  dir_row_t directed_rows [NUM_ROWS] = '{
    // window 5 out of reset: first item with no series start flag
    '{ROW_SAMPLE, PMAX,          1'b0, 1'b1, 32'h0,         1'b0},
    '{ROW_SAMPLE, PMAX,          1'b0, 1'b1, 32'h0,         1'b0},
    '{ROW_SAMPLE, PMAX,          1'b0, 1'b1, 32'h0,         1'b0},
    '{ROW_SAMPLE, PMAX,          1'b0, 1'b1, 32'h0,         1'b0},
    // five full-scale samples: 40-bit sum divides back to full scale
    '{ROW_SAMPLE, PMAX,          1'b0, 1'b1, PMAX,          1'b1},
    '{ROW_SAMPLE, 32'h0,         1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_SAMPLE, 32'h0001_0000, 1'b0, 1'b0, 32'h0,         1'b0},
    // series start in a full window drops back to empty
    '{ROW_SAMPLE, 32'h1234_5678, 1'b1, 1'b1, 32'h0,         1'b0},
    // zero window acts as one: average is the sample itself
    '{ROW_WINDOW, 32'd0,         1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_SAMPLE, PMAX,          1'b0, 1'b1, PMAX,          1'b1},
    '{ROW_SAMPLE, 32'h1,         1'b0, 1'b1, 32'h1,         1'b1},
    '{ROW_SAMPLE, 32'hA5A5_A5A5, 1'b1, 1'b1, 32'hA5A5_A5A5, 1'b1},
    '{ROW_WINDOW, 32'd1,         1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_SAMPLE, 32'h8000_0000, 1'b0, 1'b1, 32'h8000_0000, 1'b1},
    // oversized window clamps to the ring depth
    '{ROW_WINDOW, 32'd511,       1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_SAMPLE, PMAX,          1'b1, 1'b1, 32'h0,         1'b0},
    '{ROW_SAMPLE, 32'h5A5A_5A5A, 1'b0, 1'b1, 32'h0,         1'b0},
    '{ROW_WINDOW, 32'd2,         1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_SAMPLE, PMAX,          1'b0, 1'b1, 32'h0,         1'b0},
    '{ROW_SAMPLE, 32'hFFFF_FFFE, 1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_SAMPLE, 32'h3,         1'b0, 1'b0, 32'h0,         1'b0},
    // window change mid-series restarts the series
    '{ROW_WINDOW, 32'd3,         1'b0, 1'b0, 32'h0,         1'b0},
    '{ROW_SAMPLE, 32'h7,         1'b0, 1'b1, 32'h0,         1'b0},
    '{ROW_SAMPLE, 32'h0,         1'b0, 1'b1, 32'h0,         1'b0},
    '{ROW_SAMPLE, 32'h0000_FFFF, 1'b0, 1'b0, 32'h0,         1'b0}
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;     // [31:0] sample_price
  logic        in_tuser;     // [0] series_start
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;    // [31:0] average
  logic        out_tuser;    // [0] window_full
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [sma_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [sma_pkg::CFG_DATA_W-1:0] cfg_pwdata;
  logic [sma_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic        cfg_pready;

  // Predictor state, mirrored from the block's architectural state.
  logic [8:0]  win_len;
  logic [39:0] window_sum;
  logic [8:0]  series_count;
  logic [7:0]  ring_wr_pos;
  logic [31:0] price_ring [256];

  sma_result_t pending_averages [$];
  int unsigned fail_count;
  bit          quiet_mode;       // no idling on either side
  bit          long_hold_req;    // ask the receiver for one long hold-off

  simple_moving_average_top DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs on a handshake.
  initial begin
    #(2_000_000);
    $display("Test completed with failures");
    $finish;
  end

  function automatic void restart_series_state();
    window_sum   = '0;
    series_count = '0;
    ring_wr_pos  = '0;
  endfunction

  // Advance the boxcar state by one sample and return the expected result.
  function automatic sma_result_t predict_average(input logic [31:0] sample,
                                                  input logic start);
    logic [8:0]  eff;
    logic [7:0]  oldest;
    sma_result_t r;
    eff = (win_len == 9'd0) ? 9'd1 : ((win_len > MAX_W) ? MAX_W : win_len);
    if (start) restart_series_state();
    // Drop the sample leaving the window; a window of 256 wraps onto the write slot.
    if (series_count >= eff) begin
      oldest     = ring_wr_pos - eff[7:0];
      window_sum = window_sum - 40'(price_ring[oldest]);
    end
    window_sum              = window_sum + 40'(sample);
    price_ring[ring_wr_pos] = sample;
    ring_wr_pos             = ring_wr_pos + 8'd1;
    if (series_count < eff) series_count = series_count + 9'd1;
    if (series_count >= eff) begin
      r.average     = 32'(window_sum / 40'(eff));
      r.window_full = 1'b1;
    end else begin
      r.average     = '0;
      r.window_full = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [31:0] random_price();
    case ($urandom_range(0, 3))
      0:       return 32'($urandom_range(0, 255));
      1:       return PMAX - 32'($urandom_range(0, 255));
      default: return $urandom;
    endcase
  endfunction

  // Offer one sample transaction; record the expectation at the accepting edge.
  // A typed expectation, when given, replaces the predicted one in the queue.
  task automatic send_sample(input logic [31:0] sample, input logic start,
                             input logic known, input sma_result_t typed);
    sma_result_t predicted;
    if (!quiet_mode && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= sample;
    in_tuser  <= start;
    do @(posedge clk); while (!in_tready);
    predicted = predict_average(sample, start);
    pending_averages.push_back(known ? typed : predicted);
  endtask

  // Hold the input until every expected result is back and the block is ready again.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_averages.size() != 0 || !in_tready) @(posedge clk);
  endtask

  // APB write of window_length: setup cycle, then access cycle until pready.
  task automatic write_window(input logic [31:0] wdata);
    wait_idle();
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= WINDOW_ADDR;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    win_len = wdata[8:0];
    restart_series_state();
  endtask

  // Result side: check each accepted transaction, then pick the next tready.
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned hold_left;
    sma_result_t got;
    sma_result_t want;
    stall_left = 0;
    hold_left  = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got.average     = out_tdata;
        got.window_full = out_tuser;
        if (pending_averages.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result average=%h window_full=%b",
                     $realtime, got.average, got.window_full);
        end else begin
          want = pending_averages.pop_front();
          if (got.average !== want.average || got.window_full !== want.window_full) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch average exp=%h got=%h window_full exp=%b got=%b",
                       $realtime, want.average, got.average,
                       want.window_full, got.window_full);
          end
        end
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = 300;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!quiet_mode && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    sma_result_t typed;
    logic [8:0]  phase_win;
    int unsigned phase_items;
    int unsigned start_odds;
    logic        start;

    fail_count    = 0;
    quiet_mode    = 1'b0;
    long_hold_req = 1'b0;
    win_len       = sma_pkg::WINDOW_RESET;
    restart_series_state();
    foreach (price_ring[i]) price_ring[i] = '0;

    // Drive every input to a known value before the first edge.
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: window writes drain the block first.
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (directed_rows[r].kind == ROW_WINDOW) begin
        write_window(directed_rows[r].value);
      end else begin
        typed.average     = directed_rows[r].exp_avg;
        typed.window_full = directed_rows[r].exp_full;
        send_sample(directed_rows[r].value, directed_rows[r].start,
                    directed_rows[r].known, typed);
      end
    end

    // Random phases, one window setting each; extremes and clamped values included.
    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       phase_win = 9'd256;
        1:       phase_win = 9'd3;
        2:       phase_win = 9'd1;
        3:       phase_win = 9'd0;
        4:       phase_win = 9'($urandom_range(257, 511));
        5:       phase_win = 9'($urandom_range(2, 16));
        6:       phase_win = 9'($urandom_range(17, 64));
        default: phase_win = sma_pkg::WINDOW_RESET;
      endcase
      phase_items = (p == 0) ? 400 : 110;
      // Keep series starts rarer than a window fill so most series reach the full state.
      start_odds  = 8 * ((phase_win == 0) ? 1 : ((phase_win > MAX_W) ? 256 : phase_win)) + 20;
      if (p == 7) quiet_mode = 1'b1;
      write_window({23'($urandom), phase_win});
      for (int i = 0; i < phase_items; i++) begin
        // Let the result side back up and stall the input for a while.
        if (p == 1 && i == 20) long_hold_req = 1'b1;
        // Pause until the pipeline has fully drained, then resume mid-series.
        if (p == 2 && i == 50) wait_idle();
        start = (i == 0) || ($urandom_range(0, start_odds) == 0);
        send_sample(random_price(), start, 1'b0, typed);
      end
    end

    in_tvalid <= 1'b0;
    while (pending_averages.size() != 0) @(posedge clk);
    // Catch any stray result the block might still put out.
    repeat (64) @(posedge clk);
    if (fail_count == 0 && pending_averages.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/sma_pkg.sv
rtl/core/simple_moving_average_top.sv
tb/simple_moving_average_top_tb.sv
